// ===== rtl/core/bdei_pkg.sv =====
// bdei_pkg: shared constants, types and codes for the bounded degree edge inserter
// used by bdei_remainder and bounded_degree_edge_inserter; no dependencies
`timescale 1ns / 1ps

package bdei_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_DEGREE   = 16;

   localparam int VTX_W  = $clog2(MAX_VERTICES);
   localparam int SLOT_W = $clog2(MAX_DEGREE);
   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
   localparam int ADJ_AW = VTX_W + SLOT_W;

   localparam int CNT_W  = 11;
   localparam int LIM_W  = 5;
   localparam int WGT_W  = 8;
   localparam int RAW_W  = 32;
   localparam int STAT_W = 3;
   localparam int ADJ_W  = VTX_W + WGT_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WEIGHT   = 2'd2;

   localparam logic [STAT_W-1:0] ST_ADDED        = 3'd0;
   localparam logic [STAT_W-1:0] ST_SOURCE_FULL  = 3'd1;
   localparam logic [STAT_W-1:0] ST_SELF_LOOP    = 3'd2;
   localparam logic [STAT_W-1:0] ST_END_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_LINKED       = 3'd4;
   localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd5;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_DIV,
      FSM_RD_SRC,
      FSM_RD_END,
      FSM_CHECK,
      FSM_SCAN,
      FSM_WR_SRC,
      FSM_WR_END,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

// ===== rtl/core/bdei_remainder.sv =====
// bdei_remainder: bit-serial restoring remainder of a 32-bit word by an 11-bit divisor
// depends on bdei_pkg
`timescale 1ns / 1ps

module bdei_remainder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bdei_pkg::RAW_W-1:0]   dividend,
   input  logic [bdei_pkg::CNT_W-1:0]   divisor,
   output logic [bdei_pkg::CNT_W-1:0]   remainder,
   output bdei_pkg::rem_stat_type       stat
);

   localparam int CW = $clog2(bdei_pkg::RAW_W + 1);

   logic [bdei_pkg::RAW_W-1:0] quo_ff, quo_in;
   logic [bdei_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [bdei_pkg::CNT_W-1:0] div_ff, div_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [bdei_pkg::CNT_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[bdei_pkg::RAW_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(bdei_pkg::RAW_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[bdei_pkg::RAW_W-2:0], 1'b0};
         // one quotient bit per cycle
         if (trial >= {1'b0, div_ff}) begin
            rem_in = bdei_pkg::CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[bdei_pkg::CNT_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/bounded_degree_edge_inserter.sv =====
// bounded edge inserter: one edge insertion attempt per item with a degree per vertex
// and adjacency lists; depends on bdei_pkg and bdei_remainder
`timescale 1ns / 1ps

// One item at a time. After reset a clearing pass zeroes all 1024 entries of the degree
// memory. No item is taken during it, but configuration writes are. An item then runs
// the two bit-serial remainders (end vertex and weight, side by side). An out of range
// source goes straight to the result register. Otherwise come the degree memory reads
// of source and end vertex and, when the checks pass and the source has edges, a scan
// through the single read port of the adjacency memory. The scan stops early on a
// match. Then come the writes of source and end vertex when the edge is added, and the
// load of the result register, which waits while a stalled result is still held
// there. The block then returns to idle before the next item is taken. A new item is
// taken while the previous result still waits in the result register.
module bounded_degree_edge_inserter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdei_pkg::VTX_W-1:0]         req_source_vertex,
   input  logic [bdei_pkg::RAW_W-1:0]         req_random_end,
   input  logic [bdei_pkg::RAW_W-1:0]         req_random_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdei_pkg::STAT_W-1:0]        rsp_status,
   output logic [bdei_pkg::VTX_W-1:0]         rsp_far_vertex,
   output logic [bdei_pkg::WGT_W-1:0]         rsp_edge_weight,
   output logic [bdei_pkg::DEG_W-1:0]         rsp_source_degree,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdei_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdei_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int VW = bdei_pkg::VTX_W;
   localparam int DW = bdei_pkg::DEG_W;
   localparam int SW = bdei_pkg::SLOT_W;
   localparam int CW = bdei_pkg::CNT_W;
   localparam int WW = bdei_pkg::WGT_W;

   // configuration
   logic [CW-1:0]                vcount_ff;
   logic [bdei_pkg::LIM_W-1:0]   dlimit_ff;
   logic [WW-1:0]                mweight_ff;
   logic [CW-1:0]                n_eff;
   logic [DW-1:0]                lim_eff;
   logic [CW-1:0]                mw_eff;

   bdei_pkg::fsm_type state_ff, state_in;

   logic [VW-1:0]               clr_addr_ff, clr_addr_in;
   logic [VW-1:0]               src_ff, src_in;
   logic [VW-1:0]               end_ff, end_in;
   logic [WW-1:0]               wt_ff, wt_in;
   logic [DW-1:0]               ds_ff, ds_in;
   logic [DW-1:0]               de_ff, de_in;
   logic [DW-1:0]               scan_k_ff, scan_k_in;
   logic                        pend_ff, pend_in;
   logic [bdei_pkg::STAT_W-1:0] status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bdei_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VW-1:0]               rsp_end_ff, rsp_end_in;
   logic [WW-1:0]               rsp_wt_ff, rsp_wt_in;
   logic [DW-1:0]               rsp_deg_ff, rsp_deg_in;

   logic                        accept;
   logic                        div_start;
   logic                        load_rsp;
   logic [CW-1:0]               rem_end, rem_wt;
   bdei_pkg::rem_stat_type      stat_end, stat_wt;
   logic                        div_done;

   // degree memory
   logic [DW-1:0] deg_mem [bdei_pkg::MAX_VERTICES];
   logic          deg_rd_en, deg_we;
   logic [VW-1:0] deg_rd_addr, deg_wr_addr;
   logic [DW-1:0] deg_wr_data, deg_rd_data_ff;

   // adjacency memory, neighbor above the weight
   logic [bdei_pkg::ADJ_W-1:0]  adj_mem [bdei_pkg::MAX_VERTICES * bdei_pkg::MAX_DEGREE];
   logic                        adj_rd_en, adj_we;
   logic [bdei_pkg::ADJ_AW-1:0] adj_rd_addr, adj_wr_addr;
   logic [bdei_pkg::ADJ_W-1:0]  adj_wr_data, adj_rd_data_ff;

   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = CW'(1);
      end else if (vcount_ff > CW'(bdei_pkg::MAX_VERTICES)) begin
         n_eff = CW'(bdei_pkg::MAX_VERTICES);
      end else begin
         n_eff = vcount_ff;
      end
      if (DW'(dlimit_ff) > DW'(bdei_pkg::MAX_DEGREE)) begin
         lim_eff = DW'(bdei_pkg::MAX_DEGREE);
      end else begin
         lim_eff = DW'(dlimit_ff);
      end
      mw_eff = (mweight_ff == '0) ? CW'(1) : CW'(mweight_ff);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= CW'(1024);
         dlimit_ff  <= 5'd16;
         mweight_ff <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdei_pkg::CSR_VERTEX_COUNT: vcount_ff  <= csr_data;
            bdei_pkg::CSR_DEGREE_LIMIT: dlimit_ff  <= csr_data[bdei_pkg::LIM_W-1:0];
            bdei_pkg::CSR_MAX_WEIGHT:   mweight_ff <= csr_data[WW-1:0];
            default: ;
         endcase
      end
   end

   assign accept    = req_valid && !req_stall;
   assign div_start = accept;
   assign div_done  = stat_end.done && stat_wt.done;

   bdei_remainder u_rem_end (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_end),
      .divisor   (n_eff),
      .remainder (rem_end),
      .stat      (stat_end)
   );

   bdei_remainder u_rem_wt (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_weight),
      .divisor   (mw_eff),
      .remainder (rem_wt),
      .stat      (stat_wt)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdei_pkg::FSM_CLEAR: begin
            if (clr_addr_ff == VW'(bdei_pkg::MAX_VERTICES - 1)) begin
               state_in = bdei_pkg::FSM_IDLE;
            end
         end
         bdei_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = bdei_pkg::FSM_DIV;
            end
         end
         bdei_pkg::FSM_DIV: begin
            if (div_done) begin
               if (CW'(src_ff) >= n_eff) begin
                  state_in = bdei_pkg::FSM_DONE;
               end else begin
                  state_in = bdei_pkg::FSM_RD_SRC;
               end
            end
         end
         bdei_pkg::FSM_RD_SRC: state_in = bdei_pkg::FSM_RD_END;
         bdei_pkg::FSM_RD_END: state_in = bdei_pkg::FSM_CHECK;
         bdei_pkg::FSM_CHECK: begin
            if (ds_ff >= lim_eff || end_ff == src_ff || deg_rd_data_ff >= lim_eff) begin
               state_in = bdei_pkg::FSM_DONE;
            end else if (ds_ff == '0) begin
               state_in = bdei_pkg::FSM_WR_SRC;
            end else begin
               state_in = bdei_pkg::FSM_SCAN;
            end
         end
         bdei_pkg::FSM_SCAN: begin
            if (pend_ff && adj_rd_data_ff[bdei_pkg::ADJ_W-1:WW] == end_ff) begin
               state_in = bdei_pkg::FSM_DONE;
            end else if (!pend_ff && scan_k_ff == ds_ff) begin
               state_in = bdei_pkg::FSM_WR_SRC;
            end
         end
         bdei_pkg::FSM_WR_SRC: state_in = bdei_pkg::FSM_WR_END;
         bdei_pkg::FSM_WR_END: state_in = bdei_pkg::FSM_DONE;
         bdei_pkg::FSM_DONE: begin
            if (load_rsp) begin
               state_in = bdei_pkg::FSM_IDLE;
            end
         end
         default: state_in = bdei_pkg::FSM_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_stall   = 1'b1;
      load_rsp    = 1'b0;
      clr_addr_in = clr_addr_ff;
      src_in      = src_ff;
      end_in      = end_ff;
      wt_in       = wt_ff;
      ds_in       = ds_ff;
      de_in       = de_ff;
      scan_k_in   = scan_k_ff;
      pend_in     = 1'b0;
      status_in   = status_ff;
      deg_rd_en   = 1'b0;
      deg_rd_addr = src_ff;
      deg_we      = 1'b0;
      deg_wr_addr = src_ff;
      deg_wr_data = ds_ff + 1'b1;
      adj_rd_en   = 1'b0;
      adj_rd_addr = {src_ff, scan_k_ff[SW-1:0]};
      adj_we      = 1'b0;
      adj_wr_addr = {src_ff, ds_ff[SW-1:0]};
      adj_wr_data = {end_ff, wt_ff};
      unique case (state_ff)
         bdei_pkg::FSM_CLEAR: begin
            deg_we      = 1'b1;
            deg_wr_addr = clr_addr_ff;
            deg_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         bdei_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            src_in    = req_source_vertex;
         end
         bdei_pkg::FSM_DIV: begin
            end_in = rem_end[VW-1:0];
            wt_in  = rem_wt[WW-1:0] + 1'b1;
            if (div_done && CW'(src_ff) >= n_eff) begin
               status_in = bdei_pkg::ST_OUT_OF_RANGE;
            end
         end
         bdei_pkg::FSM_RD_SRC: begin
            deg_rd_en = 1'b1;
         end
         bdei_pkg::FSM_RD_END: begin
            ds_in       = deg_rd_data_ff;
            deg_rd_en   = 1'b1;
            deg_rd_addr = end_ff;
         end
         bdei_pkg::FSM_CHECK: begin
            de_in     = deg_rd_data_ff;
            scan_k_in = '0;
            if (ds_ff >= lim_eff) begin
               status_in = bdei_pkg::ST_SOURCE_FULL;
            end else if (end_ff == src_ff) begin
               status_in = bdei_pkg::ST_SELF_LOOP;
            end else if (deg_rd_data_ff >= lim_eff) begin
               status_in = bdei_pkg::ST_END_FULL;
            end else begin
               status_in = bdei_pkg::ST_ADDED;
            end
         end
         bdei_pkg::FSM_SCAN: begin
            // reads run one ahead of the compare
            if (scan_k_ff < ds_ff) begin
               adj_rd_en = 1'b1;
               scan_k_in = scan_k_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff && adj_rd_data_ff[bdei_pkg::ADJ_W-1:WW] == end_ff) begin
               status_in = bdei_pkg::ST_LINKED;
            end
         end
         bdei_pkg::FSM_WR_SRC: begin
            deg_we = 1'b1;
            adj_we = 1'b1;
         end
         bdei_pkg::FSM_WR_END: begin
            deg_we      = 1'b1;
            deg_wr_addr = end_ff;
            deg_wr_data = de_ff + 1'b1;
            adj_we      = 1'b1;
            adj_wr_addr = {end_ff, de_ff[SW-1:0]};
            adj_wr_data = {src_ff, wt_ff};
         end
         bdei_pkg::FSM_DONE: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_wt_in     = rsp_wt_ff;
      rsp_deg_in    = rsp_deg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_end_in    = end_ff;
         rsp_wt_in     = (status_ff == bdei_pkg::ST_ADDED) ? wt_ff : '0;
         if (status_ff == bdei_pkg::ST_OUT_OF_RANGE) begin
            rsp_deg_in = '0;
         end else if (status_ff == bdei_pkg::ST_ADDED) begin
            rsp_deg_in = ds_ff + 1'b1;
         end else begin
            rsp_deg_in = ds_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      end_ff        <= end_in;
      wt_ff         <= wt_in;
      ds_ff         <= ds_in;
      de_ff         <= de_in;
      scan_k_ff     <= scan_k_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_wt_ff     <= rsp_wt_in;
      rsp_deg_ff    <= rsp_deg_in;
      if (reset) begin
         state_ff     <= bdei_pkg::FSM_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wr_addr] <= deg_wr_data;
      end
      if (deg_rd_en) begin
         deg_rd_data_ff <= deg_mem[deg_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wr_addr] <= adj_wr_data;
      end
      if (adj_rd_en) begin
         adj_rd_data_ff <= adj_mem[adj_rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_far_vertex    = rsp_end_ff;
   assign rsp_edge_weight   = rsp_wt_ff;
   assign rsp_source_degree = rsp_deg_ff;

endmodule

// ===== test/bounded_degree_edge_inserter_test.sv =====
// testbench for bounded_degree_edge_inserter: random and directed edge insertion attempts
// checked against an in-bench graph predictor; depends on bdei_pkg and the block rtl
`timescale 1ns / 1ps

class edge_scoreboard;
   typedef struct packed {
      logic [2:0] status;
      logic [9:0] far_vertex;
      logic [7:0] edge_weight;
      logic [4:0] source_degree;
   } edge_result_type;

   logic [10:0] vertex_count;
   logic [4:0]  degree_limit;
   logic [7:0]  weight_cap;
   logic [4:0]  degree [1024];
   logic [9:0]  neighbor [1024][16];
   edge_result_type pending [$];
   int mismatches;
   int added_count;
   int status_seen [6];

   function void reset_graph();
      vertex_count = 11'd1024;
      degree_limit = 5'd16;
      weight_cap = 8'd255;
      foreach (degree[i]) degree[i] = 5'd0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [10:0] data);
      if (idx == bdei_pkg::CSR_VERTEX_COUNT) vertex_count = data;
      else if (idx == bdei_pkg::CSR_DEGREE_LIMIT) degree_limit = data[4:0];
      else if (idx == bdei_pkg::CSR_MAX_WEIGHT) weight_cap = data[7:0];
   endfunction

   function void note_attempt(logic [9:0] src, logic [31:0] r_end, logic [31:0] r_w);
      int unsigned n, lim, mw, e;
      edge_result_type res;
      bit linked;
      n = (vertex_count == 0) ? 1 : vertex_count;
      if (n > 1024) n = 1024;
      lim = (degree_limit > 16) ? 16 : degree_limit;
      mw = (weight_cap == 0) ? 1 : weight_cap;
      e = r_end % n;
      res = '0;
      res.far_vertex = e[9:0];
      if (src >= n) res.status = bdei_pkg::ST_OUT_OF_RANGE;
      else if (degree[src] >= lim) res.status = bdei_pkg::ST_SOURCE_FULL;
      else if (e == src) res.status = bdei_pkg::ST_SELF_LOOP;
      else if (degree[e] >= lim) res.status = bdei_pkg::ST_END_FULL;
      else begin
         linked = 0;
         for (int k = 0; k < degree[src]; k++)
            if (neighbor[src][k] == e[9:0]) linked = 1;
         if (linked) res.status = bdei_pkg::ST_LINKED;
         else begin
            res.status = bdei_pkg::ST_ADDED;
            res.edge_weight = 8'((r_w % mw) + 1);
            neighbor[src][degree[src]] = e[9:0];
            degree[src] = degree[src] + 1;
            neighbor[e][degree[e]] = src;
            degree[e] = degree[e] + 1;
         end
      end
      if (src < n) res.source_degree = degree[src];
      pending = {pending, res};
   endfunction

   function void check_result(edge_result_type got);
      edge_result_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %p", got);
         return;
      end
      want = pending.pop_front();
      status_seen[got.status]++;
      if (got.status == bdei_pkg::ST_ADDED) added_count++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, got);
      end
   endfunction
endclass

module bounded_degree_edge_inserter_test;
   import bdei_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [VTX_W-1:0] req_source_vertex = '0;
   logic [RAW_W-1:0] req_random_end = '0;
   logic [RAW_W-1:0] req_random_weight = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [STAT_W-1:0] rsp_status;
   logic [VTX_W-1:0] rsp_far_vertex;
   logic [WGT_W-1:0] rsp_edge_weight;
   logic [DEG_W-1:0] rsp_source_degree;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   edge_scoreboard graph_model = new();
   int idle_pct = 20;
   int hold_off = 0;
   int stuck_cycles = 0;
   int attempts_sent = 0;
   bit tx_quiet = 0;

   localparam int STUCK_LIMIT = 20000;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   bounded_degree_edge_inserter DUT (.*);

   // sample at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (req_valid && !req_stall)
            graph_model.note_attempt(req_source_vertex, req_random_end, req_random_weight);
         if (rsp_valid && !rsp_stall)
            graph_model.check_result({rsp_status, rsp_far_vertex, rsp_edge_weight,
                                      rsp_source_degree});
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no progress");
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else
         rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   task automatic write_csr(logic [1:0] idx, logic [10:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      graph_model.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_attempt(logic [9:0] src, logic [31:0] r_end, logic [31:0] r_w);
      @(negedge clock);
      while (!tx_quiet && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_source_vertex <= src;
      req_random_end <= r_end;
      req_random_weight <= r_w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      attempts_sent++;
      // valid stays high for back-to-back items, dropped by drain
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (graph_model.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_phase(int count, int nv);
      logic [9:0] s;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) s = 10'($urandom);
         else s = 10'($urandom_range(nv > 1024 ? 1023 : (nv < 2 ? 1 : nv - 1)));
         send_attempt(s, $urandom, $urandom);
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      graph_model.reset_graph();

      // directed: defaults, extremes of fields
      send_attempt(10'd0, 32'd0, 32'd0);
      send_attempt(10'd1023, 32'hffffffff, 32'hffffffff);
      send_attempt(10'd5, 32'd5, 32'd7);
      send_attempt(10'd0, 32'd1024, 32'd3);
      send_attempt(10'd0, 32'd5, 32'd3);
      send_attempt(10'd5, 32'd0, 32'd9);
      send_attempt(10'd682, 32'haaaaaaaa, 32'h55555555);
      send_attempt(10'd341, 32'h55555555, 32'haaaaaaaa);
      drain();
      // small graph, tiny limit: fills, source full, end full, out of range
      write_csr(CSR_VERTEX_COUNT, 11'd4);
      write_csr(CSR_DEGREE_LIMIT, 5'd1);
      write_csr(CSR_MAX_WEIGHT, 8'd1);
      send_attempt(10'd2, 32'd3, 32'hffffffff);
      send_attempt(10'd2, 32'd1, 32'd0);
      send_attempt(10'd1, 32'd3, 32'd0);
      send_attempt(10'd4, 32'd1, 32'd0);
      send_attempt(10'd1023, 32'd1, 32'd0);
      drain();
      // zero count, zero limit, zero weight, oversize values
      write_csr(CSR_VERTEX_COUNT, 11'd0);
      write_csr(CSR_DEGREE_LIMIT, 5'd0);
      write_csr(CSR_MAX_WEIGHT, 8'd0);
      send_attempt(10'd0, 32'd77, 32'd5);
      send_attempt(10'd1, 32'd77, 32'd5);
      drain();
      write_csr(CSR_DEGREE_LIMIT, 5'd31);
      send_attempt(10'd0, 32'd9, 32'd5);
      drain();
      write_csr(CSR_VERTEX_COUNT, 11'd2047);
      write_csr(CSR_DEGREE_LIMIT, 5'd3);
      send_attempt(10'd1023, 32'd1000, 32'd1);
      send_attempt(10'd1000, 32'd1023, 32'd1);
      drain();

      // random phases across settings; small counts keep lists dense
      write_csr(CSR_VERTEX_COUNT, 11'd8);
      write_csr(CSR_DEGREE_LIMIT, 5'd16);
      write_csr(CSR_MAX_WEIGHT, 8'd255);
      random_phase(300, 8);
      write_csr(CSR_VERTEX_COUNT, 11'd40);
      write_csr(CSR_DEGREE_LIMIT, 5'd4);
      write_csr(CSR_MAX_WEIGHT, 8'd13);
      // long stretch with no idling on either side
      idle_pct = 0;
      tx_quiet = 1;
      random_phase(300, 40);
      idle_pct = 20;
      tx_quiet = 0;
      write_csr(CSR_VERTEX_COUNT, 11'd3);
      write_csr(CSR_DEGREE_LIMIT, 5'd2);
      write_csr(CSR_MAX_WEIGHT, 8'd2);
      // receiver holds off while the sender keeps offering
      hold_off = 400;
      random_phase(250, 3);
      write_csr(CSR_VERTEX_COUNT, 11'd1024);
      write_csr(CSR_DEGREE_LIMIT, 5'd16);
      write_csr(CSR_MAX_WEIGHT, 8'd255);
      random_phase(400, 1024);
      write_csr(CSR_VERTEX_COUNT, 11'd20);
      write_csr(CSR_DEGREE_LIMIT, 5'd20);
      write_csr(CSR_MAX_WEIGHT, 8'd128);
      random_phase(300, 20);
      // shrunk count keeps old edges
      write_csr(CSR_VERTEX_COUNT, 11'd6);
      write_csr(CSR_DEGREE_LIMIT, 5'd8);
      random_phase(300, 6);

      $display("sent %0d attempts over several settings; %0d edges added",
               attempts_sent, graph_model.added_count);
      $display("status counts: %0d %0d %0d %0d %0d %0d, mismatches %0d",
               graph_model.status_seen[0], graph_model.status_seen[1],
               graph_model.status_seen[2], graph_model.status_seen[3],
               graph_model.status_seen[4], graph_model.status_seen[5],
               graph_model.mismatches);
      if (graph_model.mismatches == 0 && graph_model.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
